[rtl/khrt_pkg.sv]
// ----------------------------------------------------------------------------
// khrt_pkg
// Shared types and constants for the keyed histogram ring table.
// ----------------------------------------------------------------------------
package khrt_pkg;

  localparam logic [1:0] CMD_ACC   = 2'd0;
  localparam logic [1:0] CMD_SLOT  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] CFG_USE_INS   = 2'd0;
  localparam logic [1:0] CFG_USE_ID    = 2'd1;
  localparam logic [1:0] CFG_USE_KEY   = 2'd2;
  localparam logic [1:0] CFG_HIST_SIZE = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] ins;
    logic [31:0] id;
    logic [63:0] key_value;
    logic [31:0] count;
    logic [15:0] slot_index;
  } item_t;

endpackage

[rtl/khrt_queue.sv]
// ----------------------------------------------------------------------------
// khrt_queue
// Two-entry item queue that decouples the front end from the table engine.
// ----------------------------------------------------------------------------
module khrt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  khrt_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output khrt_pkg::item_t head
);

  khrt_pkg::item_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/khrt_front.sv]
// ----------------------------------------------------------------------------
// khrt_front
// Input stage: holds the configuration, masks disabled key parts and queues
// each item for the table engine.
// ----------------------------------------------------------------------------
module khrt_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [4:0]      cfg_data,
  output logic            use_ins,
  output logic            use_id,
  output logic            use_key,
  output logic [4:0]      ring_len,
  input  logic            in_valid,
  output logic            in_ready,
  input  khrt_pkg::item_t in_item,
  output logic            q_push,
  output khrt_pkg::item_t q_item,
  input  logic            q_full
);

  assign in_ready = ~q_full;
  assign q_push   = in_valid & ~q_full;

  always_comb begin
    q_item = in_item;
    if (!use_ins) begin
      q_item.ins = '0;
    end
    if (!use_id) begin
      q_item.id = '0;
    end
    if (!use_key) begin
      q_item.key_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_ins  <= 1'b1;
      use_id   <= 1'b1;
      use_key  <= 1'b1;
      ring_len <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        khrt_pkg::CFG_USE_INS:   use_ins  <= cfg_data[0];
        khrt_pkg::CFG_USE_ID:    use_id   <= cfg_data[0];
        khrt_pkg::CFG_USE_KEY:   use_key  <= cfg_data[0];
        khrt_pkg::CFG_HIST_SIZE: ring_len <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/khrt_engine.sv]
// ----------------------------------------------------------------------------
// khrt_engine
// Table engine: sequential key search over the entry memory, entry creation,
// cell read-modify-write and peak and total bookkeeping.
// ----------------------------------------------------------------------------
module khrt_engine #(
  parameter int TABLE_ENTRIES = 64,
  parameter int HIST_DEPTH    = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            use_ins,
  input  logic            use_id,
  input  logic            use_key,
  input  logic [4:0]      ring_len,
  input  logic            q_valid,
  input  khrt_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [5:0]      entry_slot,
  output logic [63:0]     cell_value,
  output logic [63:0]     entry_peak_out,
  output logic [63:0]     entry_total_out,
  output logic [63:0]     global_peak_out,
  output logic            table_empty,
  output logic            dropped
);

  localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int HW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = (HIST_DEPTH > 16) ? $clog2(HIST_DEPTH + 1) : 5;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_CHK, S_CLR, S_META, S_LOAD, S_MOD, S_CELL_RD, S_CELL_WR
  } state_t;

  state_t state;

  logic [63:0] key_ins_mem [TABLE_ENTRIES];
  logic [31:0] key_id_mem  [TABLE_ENTRIES];
  logic [63:0] key_key_mem [TABLE_ENTRIES];
  logic [HW-1:0] cursor_mem [TABLE_ENTRIES];
  logic [63:0] peak_mem  [TABLE_ENTRIES];
  logic [63:0] total_mem [TABLE_ENTRIES];
  logic [63:0] cell_mem  [TABLE_ENTRIES*HIST_DEPTH];
  logic [TABLE_ENTRIES-1:0] valid_bits;

  khrt_pkg::item_t cur;
  logic [EW-1:0] scan_pos;
  logic [CW-1:0] scan_cnt;
  logic [CW-1:0] used;
  logic          free_found;
  logic [EW-1:0] free_pos;
  logic [EW-1:0] hit_pos;
  logic          make_new;
  logic [63:0]   rd_ins;
  logic [31:0]   rd_id;
  logic [63:0]   rd_key;
  logic [HW-1:0] clr_idx;
  logic [HW-1:0] rd_cursor;
  logic [63:0]   rd_peak;
  logic [63:0]   rd_total;
  logic [15:0]   mod_val;
  logic [HW-1:0] cell_idx;
  logic [63:0]   rd_cell;
  logic [63:0]   new_cell;
  logic [63:0]   global_peak;
  logic [SW-1:0] size;
  logic [EW+HW-1:0] cell_addr;

  always_comb begin
    if (ring_len == 5'd0) begin
      size = SW'(1);
    end else if ({{(SW > 5 ? SW-5 : 0){1'b0}}, ring_len} > SW'(HIST_DEPTH)) begin
      size = SW'(HIST_DEPTH);
    end else begin
      size = SW'(ring_len);
    end
  end

  assign cell_addr = (EW+HW)'(hit_pos) * (EW+HW)'(HIST_DEPTH) + (EW+HW)'(cell_idx);
  assign q_pop     = (state == S_IDLE) && q_valid && !out_valid;
  assign new_cell  = rd_cell + {32'd0, cur.count};

  always_ff @(posedge clk) begin
    rd_ins <= key_ins_mem[scan_pos];
    rd_id  <= key_id_mem[scan_pos];
    rd_key <= key_key_mem[scan_pos];
    rd_cursor <= cursor_mem[hit_pos];
    rd_peak   <= peak_mem[hit_pos];
    rd_total  <= total_mem[hit_pos];
    rd_cell   <= cell_mem[cell_addr];
    if (state == S_CLR) begin
      cell_mem[(EW+HW)'(hit_pos) * (EW+HW)'(HIST_DEPTH) + (EW+HW)'(clr_idx)] <= '0;
    end
    if (state == S_CELL_WR) begin
      cell_mem[cell_addr] <= new_cell;
    end
    if (state == S_CLR && make_new) begin
      key_ins_mem[hit_pos] <= cur.ins;
      key_id_mem[hit_pos]  <= cur.id;
      key_key_mem[hit_pos] <= cur.key_value;
      cursor_mem[hit_pos]  <= '0;
      peak_mem[hit_pos]    <= '0;
      total_mem[hit_pos]   <= '0;
    end
    if (state == S_CELL_WR) begin
      if (cur.command == khrt_pkg::CMD_ACC) begin
        cursor_mem[hit_pos] <= ({{(16-HW){1'b0}}, cell_idx} + 16'd1 == 16'(size))
                               ? '0 : cell_idx + HW'(1);
      end else if (cell_idx > rd_cursor) begin
        cursor_mem[hit_pos] <= cell_idx;
      end
      peak_mem[hit_pos]  <= (rd_peak < new_cell) ? new_cell : rd_peak;
      total_mem[hit_pos] <= rd_total + {32'd0, cur.count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid_bits  <= '0;
      used        <= '0;
      global_peak <= '0;
      out_valid   <= 1'b0;
      scan_pos    <= '0;
      hit_pos     <= '0;
      make_new    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            cur             <= q_item;
            entry_slot      <= '0;
            cell_value      <= '0;
            entry_peak_out  <= '0;
            entry_total_out <= '0;
            dropped         <= 1'b0;
            scan_pos        <= '0;
            scan_cnt        <= '0;
            free_found      <= 1'b0;
            if (q_item.command == khrt_pkg::CMD_CLEAR) begin
              valid_bits      <= '0;
              used            <= '0;
              global_peak     <= '0;
              global_peak_out <= '0;
              table_empty     <= 1'b1;
              out_valid       <= 1'b1;
            end else if (q_item.command == khrt_pkg::CMD_ACC ||
                         q_item.command == khrt_pkg::CMD_SLOT) begin
              state <= S_SCAN;
            end else begin
              global_peak_out <= global_peak;
              table_empty     <= (used == '0);
              out_valid       <= 1'b1;
            end
          end
        end
        S_SCAN: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (valid_bits[scan_pos] &&
              (!use_ins || rd_ins == cur.ins) &&
              (!use_id || rd_id == cur.id) &&
              (!use_key || rd_key == cur.key_value)) begin
            hit_pos <= scan_pos;
            state   <= S_META;
          end else begin
            if (!valid_bits[scan_pos] && !free_found) begin
              free_found <= 1'b1;
              free_pos   <= scan_pos;
            end
            if (scan_cnt == CW'(TABLE_ENTRIES - 1)) begin
              if (free_found || !valid_bits[scan_pos]) begin
                hit_pos  <= free_found ? free_pos : scan_pos;
                make_new <= 1'b1;
                clr_idx  <= '0;
                state    <= S_CLR;
              end else begin
                dropped         <= 1'b1;
                global_peak_out <= global_peak;
                table_empty     <= (used == '0);
                out_valid       <= 1'b1;
                state           <= S_IDLE;
              end
            end else begin
              scan_pos <= scan_pos + EW'(1);
              scan_cnt <= scan_cnt + CW'(1);
              state    <= S_SCAN;
            end
          end
        end
        S_CLR: begin
          if (make_new) begin
            valid_bits[hit_pos] <= 1'b1;
            used     <= used + CW'(1);
            make_new <= 1'b0;
          end
          clr_idx <= clr_idx + HW'(1);
          if ({{(SW > HW ? SW-HW : 0){1'b0}}, clr_idx} == SW'(HIST_DEPTH - 1)) begin
            state <= S_META;
          end
        end
        S_META: state <= S_LOAD;
        S_LOAD: begin
          state   <= S_MOD;
          mod_val <= (cur.command == khrt_pkg::CMD_ACC) ? 16'(rd_cursor)
                                                        : cur.slot_index;
        end
        S_MOD: begin
          if (mod_val >= 16'(size)) begin
            mod_val <= mod_val - 16'(size);
          end else begin
            cell_idx <= mod_val[HW-1:0];
            state    <= S_CELL_RD;
          end
        end
        S_CELL_RD: state <= S_CELL_WR;
        S_CELL_WR: begin
          if (global_peak < new_cell) begin
            global_peak     <= new_cell;
            global_peak_out <= new_cell;
          end else begin
            global_peak_out <= global_peak;
          end
          entry_slot      <= 6'(hit_pos);
          cell_value      <= new_cell;
          entry_peak_out  <= (rd_peak < new_cell) ? new_cell : rd_peak;
          entry_total_out <= rd_total + {32'd0, cur.count};
          table_empty     <= 1'b0;
          out_valid       <= 1'b1;
          state           <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/keyed_histogram_ring_table_core.sv]
// ----------------------------------------------------------------------------
// keyed_histogram_ring_table_core
// Keyed histogram table: key lookup, entry creation and cell accumulation.
// ----------------------------------------------------------------------------
// A clear or an unused command gives its result directly; a lookup scans the
// entries in turn (up to the match, the whole table on a miss), clears the
// HIST_DEPTH cells of a new entry, then reduces the cell index modulo the ring
// length by repeated subtraction; a drop is reported after a full scan.
// One item is worked at a time; the next starts the cycle after its result is taken.
// Reset clears the table, the global peak and the configuration to defaults.
module keyed_histogram_ring_table_core #(
  parameter int TABLE_ENTRIES = 64,
  parameter int HIST_DEPTH    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [63:0] ins,
  input  logic [31:0] id,
  input  logic [63:0] key_value,
  input  logic [31:0] count,
  input  logic [15:0] slot_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  entry_slot,
  output logic [63:0] cell_value,
  output logic [63:0] entry_peak_out,
  output logic [63:0] entry_total_out,
  output logic [63:0] global_peak_out,
  output logic        table_empty,
  output logic        dropped
);

  logic            use_ins;
  logic            use_id;
  logic            use_key;
  logic [4:0]      ring_len;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  khrt_pkg::item_t in_item;
  khrt_pkg::item_t q_in;
  khrt_pkg::item_t q_head;

  assign in_item = '{command: command, ins: ins, id: id, key_value: key_value,
                     count: count, slot_index: slot_index};

  khrt_front u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .use_ins(use_ins), .use_id(use_id), .use_key(use_key), .ring_len(ring_len),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .q_push(q_push), .q_item(q_in), .q_full(q_full)
  );

  khrt_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_item(q_in), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .head(q_head)
  );

  khrt_engine #(.TABLE_ENTRIES(TABLE_ENTRIES), .HIST_DEPTH(HIST_DEPTH)) u_engine (
    .clk(clk), .rst(rst), .use_ins(use_ins), .use_id(use_id), .use_key(use_key),
    .ring_len(ring_len), .q_valid(q_valid), .q_item(q_head), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .entry_slot(entry_slot),
    .cell_value(cell_value), .entry_peak_out(entry_peak_out),
    .entry_total_out(entry_total_out), .global_peak_out(global_peak_out),
    .table_empty(table_empty), .dropped(dropped)
  );

  assert property (@(posedge clk) disable iff (rst) q_full |-> !in_ready)
    else $error("Input taken while the queue is full.");
  assert property (@(posedge clk) disable iff (rst) out_valid && dropped |-> entry_slot == 6'd0)
    else $error("Dropped item reports a table position.");
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && !out_ready |=> out_valid && $stable(cell_value))
    else $error("Result changed while stalled.");

endmodule
